// ===== src/rlbi_pkg.sv =====
// shared constants for the radial bilinear lookup core
package rlbi_pkg;

  localparam int TABLE_DEPTH_DEF = 4096;
  localparam int FRAC_BITS_DEF = 16;

  // configuration register indexes
  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] REG_GRID_STEP = 3'd3;
  localparam logic [2:0] REG_RADIAL_ROWS = 3'd4;
  localparam logic [2:0] REG_HEIGHT_COLS = 3'd5;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam int SQ_BITS = 65;   // dx^2 + dy^2
  localparam int ROOT_BITS = 33;
  localparam int CFG_W = 32;

endpackage

// ===== src/rlbi_sqrt.sv =====
// pipelined integer square root, one result bit per stage
module rlbi_sqrt import rlbi_pkg::*; #(
  parameter int TAG_W = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_vld,
  input  logic [SQ_BITS-1:0]   radicand,
  input  logic [TAG_W-1:0]     in_tag,
  output logic                 out_vld,
  output logic [ROOT_BITS-1:0] root,
  output logic [TAG_W-1:0]     out_tag
);

  localparam int NS = ROOT_BITS;
  localparam int RW = ROOT_BITS + 2;

  logic [NS:0]                vld;
  logic [SQ_BITS-1:0]         rad [NS+1];
  logic [ROOT_BITS-1:0]       rt [NS+1];
  logic [RW-1:0]              rem [NS+1];
  logic [TAG_W-1:0]           tag [NS+1];

  // stage 0 captures operands
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_vld;
    end
    rad[0] <= radicand;
    rt[0] <= '0;
    rem[0] <= '0;
    tag[0] <= in_tag;
  end

  // one digit pair per stage, most significant first
  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int K = 2 * (NS - 1 - s);
    logic [RW-1:0] rsh;
    logic [RW-1:0] trial;
    logic [1:0]    pair;
    always_comb begin
      // top pair holds only the single msb of the radicand
      pair = 2'(rad[s] >> K);
      rsh = {rem[s][RW-3:0], pair};
      trial = {rt[s][ROOT_BITS-1:0], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
      rad[s+1] <= rad[s];
      tag[s+1] <= tag[s];
      if (rsh >= trial) begin
        rem[s+1] <= rsh - trial;
        rt[s+1] <= {rt[s][ROOT_BITS-2:0], 1'b1};
      end else begin
        rem[s+1] <= rsh;
        rt[s+1] <= {rt[s][ROOT_BITS-2:0], 1'b0};
      end
    end
  end

  assign out_vld = vld[NS];
  assign root = rt[NS];
  assign out_tag = tag[NS];

endmodule

// ===== src/rlbi_div.sv =====
// pipelined restoring divider: quotient and FRAC_BITS fraction bits
module rlbi_div import rlbi_pkg::*; #(
  parameter int NUM_W = 33,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int TAG_W = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_vld,
  input  logic [NUM_W-1:0]             num,
  input  logic [30:0]                  den,
  input  logic [TAG_W-1:0]             in_tag,
  output logic                         out_vld,
  output logic [NUM_W+FRAC_BITS-1:0]   quo,
  output logic [TAG_W-1:0]             out_tag
);

  // quotient of num * 2^FRAC_BITS / den equals {int, frac} of the model
  localparam int NS = NUM_W + FRAC_BITS;
  localparam int RW = 32;

  logic [NS:0]         vld;
  logic [NS-1:0]       nm [NS+1];
  logic [NS-1:0]       q [NS+1];
  logic [RW-1:0]       rm [NS+1];
  logic [30:0]         dv [NS+1];
  logic [TAG_W-1:0]    tag [NS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_vld;
    end
    nm[0] <= {num, {FRAC_BITS{1'b0}}};
    q[0] <= '0;
    rm[0] <= '0;
    dv[0] <= (den == '0) ? 31'd1 : den;
    tag[0] <= in_tag;
  end

  // one quotient bit per stage
  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [RW:0] sh;
    logic [RW:0] df;
    always_comb begin
      sh = {rm[s], nm[s][NS-1-s]};
      df = sh - {2'b00, dv[s]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
      nm[s+1] <= nm[s];
      dv[s+1] <= dv[s];
      tag[s+1] <= tag[s];
      if (!df[RW]) begin
        rm[s+1] <= df[RW-1:0];
        q[s+1] <= {q[s][NS-2:0], 1'b1};
      end else begin
        rm[s+1] <= sh[RW-1:0];
        q[s+1] <= {q[s][NS-2:0], 1'b0};
      end
    end
  end

  assign out_vld = vld[NS];
  assign quo = q[NS];
  assign out_tag = tag[NS];

endmodule

// ===== src/rlbi_interp.sv =====
// table memory, corner fetch and bilinear blend
module rlbi_interp import rlbi_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [11:0]           wr_index,
  input  logic [17:0]           wr_value,
  input  logic                  q_vld,
  input  logic                  q_ok,
  input  logic [32:0]           ir,
  input  logic [FRAC_BITS-1:0]  fr,
  input  logic [32:0]           iz,
  input  logic [FRAC_BITS-1:0]  fz,
  input  logic [12:0]           radial_rows,
  input  logic [12:0]           height_cols,
  output logic                  res_vld,
  output logic [17:0]           res_value,
  output logic                  res_inside
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int PW = 46;   // 33 x 13 product
  localparam int MW = 18 + FRAC_BITS + 1;
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [MW-1:0] HALF = MW'(1) << (FRAC_BITS - 1);

  // two banks, each holding every table entry and read at two addresses
  logic [17:0] mem0 [TABLE_DEPTH];
  logic [17:0] mem1 [TABLE_DEPTH];

  // stage a: range check and row base product
  logic                 a_vld, a_ok;
  logic [PW-1:0]        a_base;
  logic [32:0]          a_iz;
  logic [12:0]          a_cols;
  logic [FRAC_BITS-1:0] a_fr, a_fz;
  logic                 rng_ok;

  always_comb begin
    rng_ok = q_ok && ({1'b0, ir} + 34'd1 < {21'd0, radial_rows})
                  && ({1'b0, iz} + 34'd1 < {21'd0, height_cols});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= q_vld;
    end
    a_ok <= rng_ok;
    a_base <= PW'(ir[12:0]) * PW'(height_cols);
    a_iz <= iz;
    a_cols <= height_cols;
    a_fr <= fr;
    a_fz <= fz;
  end

  // stage b: corner addresses and depth check
  logic                 b_vld, b_ok;
  logic [PW-1:0]        b_a0, b_a2;
  logic [FRAC_BITS-1:0] b_fr, b_fz;
  logic [PW-1:0]        a0_c, a2_c;

  always_comb begin
    a0_c = a_base + PW'(a_iz[12:0]);
    a2_c = a0_c + PW'(a_cols);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else begin
      b_vld <= a_vld;
    end
    b_ok <= a_ok && (a2_c + PW'(1) < PW'(TABLE_DEPTH));
    b_a0 <= a0_c;
    b_a2 <= a2_c;
    b_fr <= a_fr;
    b_fz <= a_fz;
  end

  // stage c: memory write and registered reads
  logic                 c_vld, c_ok;
  logic [FRAC_BITS-1:0] c_fr, c_fz;
  logic [17:0]          d0, d1, d2, d3;
  logic [AW-1:0]        ra0, ra2, ra1, ra3;
  logic                 wr_hit;

  always_comb begin
    ra0 = b_a0[AW-1:0];
    ra1 = ra0 + AW'(1);
    ra2 = b_a2[AW-1:0];
    ra3 = ra2 + AW'(1);
    wr_hit = wr_en && ({{(PW-12){1'b0}}, wr_index} < PW'(TABLE_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      mem0[AW'(wr_index)] <= wr_value;
      mem1[AW'(wr_index)] <= wr_value;
    end
    d0 <= mem0[ra0];
    d1 <= mem0[ra1];
    d2 <= mem1[ra2];
    d3 <= mem1[ra3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else begin
      c_vld <= b_vld;
    end
    c_ok <= b_ok;
    c_fr <= b_fr;
    c_fz <= b_fz;
  end

  // stage d: products along height
  logic                 d_vld, d_ok;
  logic [FRAC_BITS-1:0] d_fr;
  logic [MW-1:0]        p0, p1, p2, p3;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else begin
      d_vld <= c_vld;
    end
    d_ok <= c_ok;
    d_fr <= c_fr;
    p0 <= MW'(d0) * MW'(ONE - {1'b0, c_fz});
    p1 <= MW'(d1) * MW'(c_fz);
    p2 <= MW'(d2) * MW'(ONE - {1'b0, c_fz});
    p3 <= MW'(d3) * MW'(c_fz);
  end

  // stage e: round height blends
  logic                 e_vld, e_ok;
  logic [FRAC_BITS-1:0] e_fr;
  logic [17:0]          va, vb;
  logic [MW-1:0]        sa, sb;

  always_comb begin
    sa = p0 + p1 + HALF;
    sb = p2 + p3 + HALF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else begin
      e_vld <= d_vld;
    end
    e_ok <= d_ok;
    e_fr <= d_fr;
    va <= sa[FRAC_BITS +: 18];
    vb <= sb[FRAC_BITS +: 18];
  end

  // stage f: products along radius
  logic          f_vld, f_ok;
  logic [MW-1:0] pa, pb;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else begin
      f_vld <= e_vld;
    end
    f_ok <= e_ok;
    pa <= MW'(va) * MW'(ONE - {1'b0, e_fr});
    pb <= MW'(vb) * MW'(e_fr);
  end

  // stage g: final rounding and result register
  logic [MW-1:0] sf;
  always_comb begin
    sf = pa + pb + HALF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else begin
      res_vld <= f_vld;
    end
    res_inside <= f_ok;
    res_value <= f_ok ? sf[FRAC_BITS +: 18] : 18'd0;
  end

  // outside results carry a zero factor
  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    res_vld && !res_inside |-> res_value == 18'd0)
    else $error("outside result with nonzero factor");
  a_vld_follow: assert property (@(posedge clk) disable iff (rst)
    f_vld |=> res_vld)
    else $error("result beat lost");
  a_ok_addr: assert property (@(posedge clk) disable iff (rst)
    b_vld && b_ok |-> b_a2 + PW'(1) < PW'(TABLE_DEPTH))
    else $error("corner address beyond depth");

endmodule

// ===== src/radial_lut_bilinear_interp_core.sv =====
// a query passes 3 + 34 + 50 + 7 register stages from the accepting edge to its done pulse
// throughput: one item per cycle, set by the pipelined root and dividers
// a write item gives no result; it trails the query pipeline by 89 stages and
// reaches the table memory in acceptance order with the query reads
// reset clears configuration to defaults and empties the pipeline
// the table is undefined until written; the receiver cannot stall
module radial_lut_bilinear_interp_core import rlbi_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               func,
  input  logic [11:0]        entry_index,
  input  logic [17:0]        entry_value,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  output logic               done,
  output logic [17:0]        scale_factor,
  output logic               inside_res
);

  localparam int QW = 33 + FRAC_BITS;
  // stages from acceptance to the table read of a query
  localparam int WR_DLY = 3 + (ROOT_BITS + 1) + (33 + FRAC_BITS + 1) + 2;

  // configuration registers
  logic signed [31:0] origin_x, origin_y, origin_z;
  logic [30:0]        grid_step;
  logic [12:0]        radial_rows, height_cols;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
      origin_z <= '0;
      grid_step <= 31'd131072;
      radial_rows <= 13'd64;
      height_cols <= 13'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X: origin_x <= cfg_data;
        REG_ORIGIN_Y: origin_y <= cfg_data;
        REG_ORIGIN_Z: origin_z <= cfg_data;
        REG_GRID_STEP: grid_step <= cfg_data[30:0];
        REG_RADIAL_ROWS: radial_rows <= cfg_data[12:0];
        REG_HEIGHT_COLS: height_cols <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic acc;
  assign acc = start && !busy;

  // stage 1: origin differences
  logic               s1_vld;
  logic signed [32:0] dx, dy, dz;
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= acc && (func == FUNC_QUERY);
    end
    dx <= 33'(pos_x) - 33'(origin_x);
    dy <= 33'(pos_y) - 33'(origin_y);
    dz <= 33'(pos_z) - 33'(origin_z);
  end

  // write beats trail the query pipeline so table updates stay in order
  logic [WR_DLY-1:0] wd_vld;
  logic [11:0]       wd_idx [WR_DLY];
  logic [17:0]       wd_val [WR_DLY];
  always_ff @(posedge clk) begin
    if (rst) begin
      wd_vld <= '0;
    end else begin
      wd_vld <= {wd_vld[WR_DLY-2:0], acc && (func == FUNC_WRITE)};
    end
    wd_idx[0] <= entry_index;
    wd_val[0] <= entry_value;
    for (int i = 1; i < WR_DLY; i++) begin
      wd_idx[i] <= wd_idx[i-1];
      wd_val[i] <= wd_val[i-1];
    end
  end

  // stage 2: squares
  logic        s2_vld, s2_neg;
  logic [63:0] sqx, sqy;
  logic [31:0] s2_dz;
  logic [32:0] mx, my;
  always_comb begin
    mx = dx[32] ? 33'(-dx) : 33'(dx);
    my = dy[32] ? 33'(-dy) : 33'(dy);
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
    sqx <= 64'(mx) * 64'(mx);
    sqy <= 64'(my) * 64'(my);
    s2_neg <= dz[32];
    s2_dz <= dz[31:0];
  end

  // stage 3: sum of squares
  logic               s3_vld;
  logic [SQ_BITS-1:0] s3_sum;
  logic [32:0]        s3_tag;
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else begin
      s3_vld <= s2_vld;
    end
    s3_sum <= {1'b0, sqx} + {1'b0, sqy};
    s3_tag <= {s2_neg, s2_dz};
  end

  // radius
  logic                 r_vld;
  logic [ROOT_BITS-1:0] r_root;
  logic [32:0]          r_tag;
  rlbi_sqrt #(.TAG_W(33)) u_sqrt (
    .clk(clk), .rst(rst), .in_vld(s3_vld), .radicand(s3_sum), .in_tag(s3_tag),
    .out_vld(r_vld), .root(r_root), .out_tag(r_tag)
  );

  // radius and height through matched dividers
  logic          qr_vld, qz_vld;
  logic [QW-1:0] qr, qz;
  logic          z_neg, z_neg_unused;
  rlbi_div #(.NUM_W(33), .FRAC_BITS(FRAC_BITS), .TAG_W(1)) u_div_r (
    .clk(clk), .rst(rst), .in_vld(r_vld), .num(r_root), .den(grid_step),
    .in_tag(r_tag[32]), .out_vld(qr_vld), .quo(qr), .out_tag(z_neg)
  );
  rlbi_div #(.NUM_W(33), .FRAC_BITS(FRAC_BITS), .TAG_W(1)) u_div_z (
    .clk(clk), .rst(rst), .in_vld(r_vld), .num({1'b0, r_tag[31:0]}),
    .den(grid_step), .in_tag(r_tag[32]), .out_vld(qz_vld), .quo(qz),
    .out_tag(z_neg_unused)
  );

  rlbi_interp #(.TABLE_DEPTH(TABLE_DEPTH), .FRAC_BITS(FRAC_BITS)) u_interp (
    .clk(clk), .rst(rst),
    .wr_en(wd_vld[WR_DLY-1]), .wr_index(wd_idx[WR_DLY-1]),
    .wr_value(wd_val[WR_DLY-1]),
    .q_vld(qr_vld), .q_ok(!z_neg),
    .ir(qr[QW-1:FRAC_BITS]), .fr(qr[FRAC_BITS-1:0]),
    .iz(qz[QW-1:FRAC_BITS]), .fz(qz[FRAC_BITS-1:0]),
    .radial_rows(radial_rows), .height_cols(height_cols),
    .res_vld(done), .res_value(scale_factor), .res_inside(inside_res)
  );

  a_div_match: assert property (@(posedge clk) disable iff (rst)
    qr_vld == qz_vld)
    else $error("divider pipelines out of step");
  a_tag_match: assert property (@(posedge clk) disable iff (rst)
    qr_vld |-> z_neg == z_neg_unused)
    else $error("height sign tag mismatch");
  a_write_quiet: assert property (@(posedge clk) disable iff (rst)
    acc && func == FUNC_WRITE |=> !s1_vld)
    else $error("write beat entered query pipeline");

endmodule

// ===== test/radial_lut_bilinear_interp_core_tb.sv =====
// testbench for the radial bilinear lookup core: table fill, queries, checks against a predictor
`timescale 1ns / 100ps

module radial_lut_bilinear_interp_core_tb;
  import rlbi_pkg::*;

  localparam int DEPTH = 4096;
  localparam int FILL = 512;
  localparam int FBITS = 16;
  localparam int DRAIN_CYCLES = 120;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic        func;
    logic [11:0] idx;
    logic [17:0] val;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
  } beat_t;

  typedef struct {
    logic [17:0] factor;
    logic        in_tbl;
  } lookup_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic func = FUNC_WRITE;
  logic [11:0] entry_index = '0;
  logic [17:0] entry_value = '0;
  logic signed [31:0] pos_x = '0;
  logic signed [31:0] pos_y = '0;
  logic signed [31:0] pos_z = '0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = REG_ORIGIN_X;
  logic [CFG_W-1:0] cfg_data = '0;
  logic done;
  logic [17:0] scale_factor;
  logic inside_res;

  radial_lut_bilinear_interp_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .entry_index(entry_index), .entry_value(entry_value),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .scale_factor(scale_factor), .inside_res(inside_res)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the block's configuration and table
  longint ox, oy, oz;
  longint unsigned gstep, rows, cols;
  logic [17:0] factor_mem [DEPTH];

  beat_t pending_q[$];
  lookup_t lookup_q[$];
  beat_t cur;
  bit took;
  int idle_pct = 0;
  int errors = 0;
  int n_queries = 0, n_writes = 0, n_inside = 0, n_checked = 0;
  int quiet = 0;

  function automatic logic [32:0] root_of(logic [65:0] v);
    logic [65:0] rem;
    logic [65:0] trial;
    logic [32:0] root;
    root = '0;
    rem = '0;
    for (int i = 32; i >= 0; i--) begin
      rem = (rem << 2) | v[2*i +: 2];
      trial = {root, 2'b01};
      if (rem >= trial) begin
        rem = rem - trial;
        root = {root[31:0], 1'b1};
      end else begin
        root = {root[31:0], 1'b0};
      end
    end
    return root;
  endfunction

  function automatic longint unsigned blend(longint unsigned a, longint unsigned b,
                                            longint unsigned f);
    return (a * ((64'd1 << FBITS) - f) + b * f + (64'd1 << (FBITS - 1))) >> FBITS;
  endfunction

  // expected lookup for one query point
  function automatic lookup_t lookup_point(beat_t b);
    lookup_t res;
    longint unsigned step, ax, ay, r, ir, fr, iz, fz, a0, a2, va, vb;
    longint dx, dy, dz;
    logic [65:0] sq;
    res.factor = '0;
    res.in_tbl = 1'b0;
    step = (gstep == 0) ? 1 : gstep;
    dx = longint'(signed'(b.px)) - ox;
    dy = longint'(signed'(b.py)) - oy;
    dz = longint'(signed'(b.pz)) - oz;
    if (dz < 0) return res;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    sq = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
    r = root_of(sq);
    ir = r / step;
    fr = ((r % step) << FBITS) / step;
    iz = longint'(dz) / step;
    fz = ((longint'(dz) % step) << FBITS) / step;
    if (ir + 1 >= rows || iz + 1 >= cols) return res;
    a0 = ir * cols + iz;
    a2 = (ir + 1) * cols + iz;
    if (a2 + 1 >= DEPTH) return res;
    va = blend(factor_mem[a0], factor_mem[a0 + 1], fz);
    vb = blend(factor_mem[a2], factor_mem[a2 + 1], fz);
    res.factor = 18'(blend(va, vb, fr));
    res.in_tbl = 1'b1;
    return res;
  endfunction

  // driver: present the next beat at the falling edge
  always @(negedge clk) begin
    if (!start || took) begin
      if (!rst && pending_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        cur = pending_q.pop_front();
        func <= cur.func;
        entry_index <= cur.idx;
        entry_value <= cur.val;
        pos_x <= cur.px;
        pos_y <= cur.py;
        pos_z <= cur.pz;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: accepted beats, config writes and results
  always @(posedge clk) begin
    took = start && !busy && !rst;
    if (rst) begin
      ox = 0; oy = 0; oz = 0;
      gstep = 131072; rows = 64; cols = 64;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X: ox = longint'(signed'(cfg_data));
        REG_ORIGIN_Y: oy = longint'(signed'(cfg_data));
        REG_ORIGIN_Z: oz = longint'(signed'(cfg_data));
        REG_GRID_STEP: gstep = cfg_data[30:0];
        REG_RADIAL_ROWS: rows = cfg_data[12:0];
        REG_HEIGHT_COLS: cols = cfg_data[12:0];
        default: ;
      endcase
    end
    if (!rst && done) begin
      if (lookup_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result factor=%0d inside=%0b", $time, scale_factor, inside_res);
      end else begin
        lookup_t e;
        e = lookup_q.pop_front();
        n_checked++;
        if (scale_factor !== e.factor) begin
          errors++;
          $display("%0t: scale_factor expected %0d actual %0d", $time, e.factor, scale_factor);
        end
        if (inside_res !== e.in_tbl) begin
          errors++;
          $display("%0t: inside_res expected %0b actual %0b", $time, e.in_tbl, inside_res);
        end
      end
    end
    if (took) begin
      if (cur.func == FUNC_WRITE) begin
        factor_mem[cur.idx] = cur.val;
        n_writes++;
      end else begin
        lookup_t p;
        p = lookup_point(cur);
        n_queries++;
        if (p.in_tbl) n_inside++;
        lookup_q.push_back(p);
      end
    end
  end

  // watchdog on cycles with no beat moving either way
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  task automatic push_write(int idx, int val);
    beat_t b;
    b = '{FUNC_WRITE, 12'(idx), 18'(val), 32'($urandom), 32'($urandom), 32'($urandom)};
    pending_q.push_back(b);
  endtask

  task automatic push_query(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    beat_t b;
    b = '{FUNC_QUERY, 12'($urandom), 18'($urandom), px, py, pz};
    pending_q.push_back(b);
  endtask

  // wait until the block has drained, then write one register
  task automatic set_reg(logic [2:0] idx, logic [31:0] val);
    while (pending_q.size() != 0 || start || lookup_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // offset along one axis over seven tenths of the tabled span, either sign
  function automatic logic [31:0] near(longint o, longint unsigned span);
    longint unsigned lim, d;
    lim = (span * 7) / 10;
    if (lim > 64'hFFFF_FFFF) lim = 64'hFFFF_FFFF;
    d = {$urandom, $urandom} % (lim + 1);
    return ($urandom_range(1)) ? 32'(o + longint'(d)) : 32'(o - longint'(d));
  endfunction

  // random part: mostly points inside the table, some noise and writes
  task automatic random_beats(int n);
    longint unsigned sr, sz, st;
    int k;
    st = (gstep == 0) ? 1 : gstep;
    sr = rows * st;
    sz = cols * st;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 70) begin
        push_query(near(ox, sr), near(oy, sr / 2),
                   $urandom_range(9) == 0 ? 32'(oz - 1 - $urandom_range(1000)) :
                   32'(oz + longint'({$urandom, $urandom} % (sz + 1))));
      end else if (k < 85) begin
        push_query($urandom, $urandom, $urandom);
      end else begin
        push_write($urandom_range(DEPTH - 1), $urandom_range(262143));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // full rate: fill every entry that the settings below can reach
    idle_pct = 0;
    for (int i = 0; i < FILL; i++) push_write(i, $urandom_range(262143));
    for (int i = 2048; i < 2056; i++) push_write(i, $urandom_range(262143));
    push_write(0, 262143);
    push_write(1, 262143);
    push_write(64, 262143);
    push_write(65, 262143);
    push_write(4095, 0);

    // defaults: directed points near the origin and at the edges
    push_query(32'h0, 32'h0, 32'h0);
    push_query(32'h0001_8000, 32'h0, 32'h0000_C000);
    push_query(32'h0, 32'h0, 32'hFFFF_FFFF);
    push_query(32'h8000_0000, 32'h0, 32'h0);
    push_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_query(32'h0, 32'h0, 32'h8000_0000);
    push_query(32'h0, 32'h0, 32'h007C_0000);
    push_query(32'h0, 32'h0, 32'h007E_0000);
    push_query(32'h007E_0000, 32'h0, 32'h0);
    push_query(32'hFFFF_0000, 32'h0001_0000, 32'h0002_0000);

    // smaller table at the default origin and step
    set_reg(REG_RADIAL_ROWS, 16);
    set_reg(REG_HEIGHT_COLS, 32);
    push_query(32'h001C_0000, 32'h0, 32'h0001_0000);
    push_query(32'h001E_0000, 32'h0, 32'h0001_0000);
    random_beats(250);

    // narrow table, sender mostly idle
    set_reg(REG_ORIGIN_X, 32'h00A0_0000);
    set_reg(REG_ORIGIN_Y, 32'hFF60_0000);
    set_reg(REG_ORIGIN_Z, $urandom_range(32'h0100_0000));
    set_reg(REG_GRID_STEP, 32'h0001_0000);
    set_reg(REG_RADIAL_ROWS, 4);
    set_reg(REG_HEIGHT_COLS, 128);
    idle_pct = 81;
    random_beats(250);

    // extreme origins and step, radius sum beyond 64 bits, far corners past the memory
    set_reg(REG_ORIGIN_X, 32'h8000_0000);
    set_reg(REG_ORIGIN_Y, 32'h7FFF_FFFF);
    set_reg(REG_ORIGIN_Z, 32'h8000_0000);
    set_reg(REG_GRID_STEP, 32'h7FFF_FFFF);
    set_reg(REG_RADIAL_ROWS, 3);
    set_reg(REG_HEIGHT_COLS, 2048);
    idle_pct = 0;
    push_query(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    push_query(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    push_query(32'h0, 32'h7FFF_FFFF, 32'h8000_0000);
    random_beats(200);

    // zero step acts as one, big row count
    set_reg(REG_ORIGIN_X, 0);
    set_reg(REG_ORIGIN_Y, 0);
    set_reg(REG_ORIGIN_Z, 0);
    set_reg(REG_GRID_STEP, 0);
    set_reg(REG_RADIAL_ROWS, 4096);
    set_reg(REG_HEIGHT_COLS, 1);
    idle_pct = 28;
    random_beats(60);
    set_reg(REG_RADIAL_ROWS, 16);
    set_reg(REG_HEIGHT_COLS, 32);
    random_beats(200);

    // zero rows: everything outside
    set_reg(REG_GRID_STEP, 229376);
    set_reg(REG_RADIAL_ROWS, 0);
    set_reg(REG_HEIGHT_COLS, 8191);
    idle_pct = 81;
    random_beats(60);

    // drain and report
    while (pending_q.size() != 0 || start || lookup_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("covered %0d table writes and %0d queries, %0d inside the table",
             n_writes, n_queries, n_inside);
    $display("%0d results checked over several register settings, %0d mismatches",
             n_checked, errors);
    if (errors == 0 && lookup_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
